/* rtl/core/cpf_pkg.sv */
package cpf_pkg;

  // Capacity of the value table; positions at or above it are dropped.
  localparam int TBL_DEPTH = 1024;
  localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  // Item counter saturates at TBL_DEPTH + 1.
  localparam int CNT_W     = $clog2(TBL_DEPTH + 2);
  localparam int IDX_W     = 10;
  localparam int EPOCH_W   = 8;
  localparam int VAL_W     = 32;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last_item;
  } cpf_in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] later_index;
    logic [IDX_W-1:0] earlier_index;
    logic             overflowed;
  } cpf_out_t;

  // Epoch 0 is never a live epoch, so a swept entry reads as empty.
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [VAL_W-1:0]   key;
    logic [TBL_AW-1:0]  pos;
  } cpf_entry_t;

endpackage

/* rtl/core/complement_pair_finder.sv */
// Two-sum finder. Array elements stream in on the in_ channel (valid/stall),
// one signed 32-bit value per transfer, with last_item on the final element.
// For each element the complement (target_sum - value, 33 bits) is looked up
// in a hashed value->position table held in one synchronous RAM. A hit gives
// one out_ transfer with found=1 and both positions; the rest of that array
// is then ignored. An array that ends without a pair gives one transfer with
// found=0, and overflowed=1 if it held more than TBL_DEPTH elements.
// cfg_ writes target_sum (reset 0); write it only while the block is idle.
// Items are taken one at a time: the next is accepted only once the last is
// through. Each item probes the table by linear probing, first along the
// complement's chain, then along the value's chain for the insert; a dropped
// item skips the probes. A result passes the probe states and then the
// output register on its way to out_.
// The table is emptied after each last element by bumping an epoch tag kept
// in every entry. After reset, and after every 255 arrays when the tag wraps,
// a sweep rewrites all TBL_DEPTH (1024) RAM entries and in_stall stays high.
// A result waiting on out_stall is held in the output register while the next
// item is already taken; a later result waits until that slot drains.
module complement_pair_finder
  import cpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cpf_in_t          in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output cpf_out_t         out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VAL_W-1:0] cfg_data
);

  logic [VAL_W-1:0] target_r;
  logic             item_ready;
  logic             res_valid;
  cpf_out_t         res;
  logic             slot_free;
  logic             out_valid_r;
  cpf_out_t         out_item_r;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_valid) begin
      target_r <= cfg_data;
    end
  end

  cpf_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .target     (target_r),
    .item_valid (in_valid),
    .item       (in_item),
    .item_ready (item_ready),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (slot_free)
  );

  assign in_stall = !item_ready;

  // output register: free when empty or being drained this cycle
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/core/cpf_table.sv */
module cpf_table
  import cpf_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [TBL_AW-1:0] wr_addr,
  input  cpf_entry_t        wr_data,
  input  logic [TBL_AW-1:0] rd_addr,
  output cpf_entry_t        rd_data_r
);

  cpf_entry_t mem [TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

/* rtl/core/cpf_engine.sv */
module cpf_engine
  import cpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [VAL_W-1:0]  target,
  input  logic              item_valid,
  input  cpf_in_t           item,
  output logic              item_ready,
  output logic              res_valid,
  output cpf_out_t          res,
  input  logic              res_ready
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_PROBE_C,
    ST_PROBE_V,
    ST_FINISH
  } state_t;

  state_t             state_r;
  logic [TBL_AW-1:0]  clr_addr_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [CNT_W-1:0]   item_count_r;
  logic               pair_done_r;
  logic [VAL_W-1:0]   value_r;
  logic               last_r;
  logic [VAL_W:0]     comp_r;
  logic [CNT_W-1:0]   pos_r;
  logic               hit_r;
  logic [TBL_AW-1:0]  earlier_r;
  logic [TBL_AW-1:0]  probe_addr_r;

  logic [TBL_AW-1:0]  rd_addr;
  logic               wr_en;
  logic [TBL_AW-1:0]  wr_addr;
  cpf_entry_t         wr_data;
  cpf_entry_t         rd_data_r;

  logic               slot_live;
  logic               comp_hit;
  logic               val_match;
  logic               comp_in_range;
  logic [TBL_AW-1:0]  next_addr;
  logic [TBL_AW-1:0]  comp_hash;
  logic [TBL_AW-1:0]  val_hash;

  // XOR fold of the key onto the address bits, then one reduce into range.
  function automatic logic [TBL_AW-1:0] hash_key(input logic [VAL_W-1:0] k);
    logic [TBL_AW-1:0] h;
    h = '0;
    for (int i = 0; i < VAL_W; i++) begin
      h[i % TBL_AW] = h[i % TBL_AW] ^ k[i];
    end
    if (32'(h) >= TBL_DEPTH) begin
      h = h - TBL_AW'(TBL_DEPTH);
    end
    return h;
  endfunction

  cpf_table u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  assign slot_live     = (rd_data_r.epoch == epoch_r);
  assign comp_hit      = slot_live && (rd_data_r.key == comp_r[VAL_W-1:0]);
  assign val_match     = slot_live && (rd_data_r.key == value_r);
  assign comp_in_range = (comp_r[VAL_W] == comp_r[VAL_W-1]);
  assign next_addr     = (probe_addr_r == TBL_AW'(TBL_DEPTH - 1)) ? '0
                                                                  : probe_addr_r + 1'b1;
  assign comp_hash     = hash_key(comp_r[VAL_W-1:0]);
  assign val_hash      = hash_key(value_r);

  always_comb begin
    item_ready = (state_r == ST_IDLE);
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = probe_addr_r;
    wr_data    = '{epoch: epoch_r, key: value_r, pos: TBL_AW'(pos_r)};
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
      end
      ST_PREP: begin
        rd_addr = comp_in_range ? comp_hash : val_hash;
      end
      ST_PROBE_C: begin
        rd_addr = slot_live ? next_addr : val_hash;
      end
      ST_PROBE_V: begin
        rd_addr = next_addr;
        // empty slot -> insert; same key -> newer position
        wr_en   = !slot_live || val_match;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_valid         = (state_r == ST_FINISH) && (hit_r || (last_r && !pair_done_r));
    res.found         = hit_r;
    res.later_index   = hit_r ? IDX_W'(pos_r) : '0;
    res.earlier_index = hit_r ? IDX_W'(earlier_r) : '0;
    res.overflowed    = !hit_r && (item_count_r > CNT_W'(TBL_DEPTH));
  end

  always_ff @(posedge clk) begin
    // tracks the address behind rd_data_r
    probe_addr_r <= rd_addr;
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      epoch_r      <= '0;
      item_count_r <= '0;
      pair_done_r  <= 1'b0;
      hit_r        <= 1'b0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == TBL_AW'(TBL_DEPTH - 1)) begin
            epoch_r <= EPOCH_W'(1);
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            value_r <= item.value;
            last_r  <= item.last_item;
            comp_r  <= {target[VAL_W-1], target} - {item.value[VAL_W-1], item.value};
            pos_r   <= item_count_r;
            hit_r   <= 1'b0;
            if (item_count_r <= CNT_W'(TBL_DEPTH)) begin
              item_count_r <= item_count_r + 1'b1;
            end
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (!pair_done_r && (pos_r < CNT_W'(TBL_DEPTH))) begin
            state_r <= comp_in_range ? ST_PROBE_C : ST_PROBE_V;
          end else begin
            state_r <= ST_FINISH;
          end
        end
        ST_PROBE_C: begin
          if (comp_hit) begin
            hit_r       <= 1'b1;
            earlier_r   <= rd_data_r.pos;
            pair_done_r <= 1'b1;
            state_r     <= ST_FINISH;
          end else if (!slot_live) begin
            state_r <= ST_PROBE_V;
          end
        end
        ST_PROBE_V: begin
          if (wr_en) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!res_valid || res_ready) begin
            if (last_r) begin
              item_count_r <= '0;
              pair_done_r  <= 1'b0;
              if (epoch_r == '1) begin
                clr_addr_r <= '0;
                state_r    <= ST_CLEAR;
              end else begin
                epoch_r <= epoch_r + 1'b1;
                state_r <= ST_IDLE;
              end
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
